### rtl/owtr_pkg.sv
package owtr_pkg;

	localparam int TIMER_BITS = 20;
	localparam int CFG_W      = 20;
	localparam int TEMP_W     = 16;

	localparam logic [7:0] CMD_SKIP    = 8'hCC;
	localparam logic [7:0] CMD_CONVERT = 8'h44;
	localparam logic [7:0] CMD_READSP  = 8'hBE;

	typedef struct packed {
		logic                     pull_low;
		logic                     busy_res;
		logic                     done_res;
		logic                     no_device;
		logic signed [TEMP_W-1:0] raw_temperature;
	} result_t;

endpackage

### rtl/owtr_if.sv
interface owtr_tick_if;
	logic valid;
	logic ready;
	logic start_req;
	logic line_level;

	modport source (output valid, output start_req, output line_level, input ready);
	modport sink (input valid, input start_req, input line_level, output ready);
endinterface

interface owtr_result_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  pull_low;
	logic                                  busy_res;
	logic                                  done_res;
	logic                                  no_device;
	logic signed [owtr_pkg::TEMP_W-1:0]    raw_temperature;

	modport source (output valid, output pull_low, output busy_res, output done_res,
		output no_device, output raw_temperature, input ready);
	modport sink (input valid, input pull_low, input busy_res, input done_res,
		input no_device, input raw_temperature, output ready);
endinterface

interface owtr_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [owtr_pkg::CFG_W-1:0]   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/owtr_seq.sv
module owtr_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          start_req,
	input  logic                          line_level,
	input  logic [owtr_pkg::CFG_W-1:0]    wait_cfg,
	output owtr_pkg::result_t             res
);

	localparam int TB = owtr_pkg::TIMER_BITS;
	localparam int CW = 25;
	localparam logic [TB-1:0] TMASK = {TB{1'b1}};

	localparam logic [4:0] PH_IDLE   = 5'd0;
	localparam logic [4:0] PH_RST1   = 5'd1;
	localparam logic [4:0] PH_WSKIP1 = 5'd2;
	localparam logic [4:0] PH_WCONV  = 5'd3;
	localparam logic [4:0] PH_WAIT   = 5'd4;
	localparam logic [4:0] PH_RST2   = 5'd5;
	localparam logic [4:0] PH_WSKIP2 = 5'd6;
	localparam logic [4:0] PH_WREAD  = 5'd7;
	localparam logic [4:0] PH_READ   = 5'd8;

	logic [4:0]    phase_q, phase_d, cur_ph, ent_ph, ent_fin;
	logic [TB-1:0] tmr_q, tmr_d, t;
	logic [2:0]    bit_q, bit_d;
	logic          bstep_q, bstep_d;
	logic [7:0]    sh_q, sh_d;
	logic [15:0]   acc_q, acc_d;
	logic          err_q, err_d;
	logic          ent;
	logic [TB-1:0] wait_len;

	// saturate the conversion wait to the timer range
	always_comb begin
		if (CW'(wait_cfg) > CW'(TMASK))
			wait_len = TMASK;
		else
			wait_len = TB'(wait_cfg);
	end

	always_comb begin
		phase_d = phase_q;
		tmr_d   = tmr_q;
		bit_d   = bit_q;
		bstep_d = bstep_q;
		sh_d    = sh_q;
		acc_d   = acc_q;
		err_d   = err_q;
		cur_ph  = phase_q;
		t       = tmr_q;
		ent     = 1'b0;
		ent_ph  = PH_IDLE;
		ent_fin = PH_IDLE;
		res     = '0;

		if (phase_q == PH_IDLE && start_req) begin
			err_d   = 1'b0;
			bstep_d = 1'b0;
			acc_d   = '0;
			cur_ph  = PH_RST1;
			phase_d = PH_RST1;
			t       = '0;
			bit_d   = '0;
		end

		if (cur_ph != PH_IDLE) begin
			tmr_d = t + TB'(1);
			unique case (cur_ph)
				PH_RST1, PH_RST2: begin
					res.pull_low = (t < TB'(480));
					if (t == TB'(540) && line_level)
						err_d = 1'b1;
					if (t >= TB'(959)) begin
						if (err_d) begin
							res.done_res  = 1'b1;
							res.no_device = 1'b1;
							phase_d       = PH_IDLE;
							tmr_d         = '0;
						end else begin
							ent    = 1'b1;
							ent_ph = cur_ph + 5'd1;
						end
					end
				end
				PH_WSKIP1, PH_WCONV, PH_WSKIP2, PH_WREAD: begin
					res.pull_low = sh_q[0] ? (t < TB'(10)) : (t < TB'(60));
					if (t >= TB'(69)) begin
						sh_d  = {1'b0, sh_q[7:1]};
						bit_d = bit_q + 3'd1;
						tmr_d = '0;
						if (bit_d == 3'd0) begin
							ent    = 1'b1;
							ent_ph = (cur_ph == PH_WCONV) ? PH_WAIT : cur_ph + 5'd1;
						end
					end
				end
				PH_WAIT: begin
					if ((TB+1)'(t) + (TB+1)'(1) >= (TB+1)'(wait_len)) begin
						ent    = 1'b1;
						ent_ph = PH_RST2;
					end
				end
				PH_READ: begin
					res.pull_low = (t == '0);
					if (t == TB'(15))
						sh_d = sh_q | (8'(line_level) << bit_q);
					if (t >= TB'(59)) begin
						bit_d = bit_q + 3'd1;
						tmr_d = '0;
						if (bit_d == 3'd0) begin
							if (!bstep_q) begin
								acc_d   = {8'h00, sh_d};
								bstep_d = 1'b1;
								sh_d    = '0;
							end else begin
								acc_d               = {sh_d, acc_q[7:0]};
								res.done_res        = 1'b1;
								res.raw_temperature = acc_d;
								phase_d             = PH_IDLE;
								bstep_d             = 1'b0;
							end
						end
					end
				end
				default: begin
					phase_d = PH_IDLE;
					tmr_d   = '0;
				end
			endcase
		end

		// enter the next phase (a zero wait goes on to the second reset): restart the slot, load the command byte
		if (ent) begin
			ent_fin = (ent_ph == PH_WAIT && wait_len == '0) ? PH_RST2 : ent_ph;
			phase_d = ent_fin;
			tmr_d   = '0;
			bit_d   = '0;
			if (ent_fin == PH_WSKIP1 || ent_fin == PH_WSKIP2)
				sh_d = owtr_pkg::CMD_SKIP;
			else if (ent_fin == PH_WCONV)
				sh_d = owtr_pkg::CMD_CONVERT;
			else if (ent_fin == PH_WREAD)
				sh_d = owtr_pkg::CMD_READSP;
			else if (ent_fin == PH_READ)
				sh_d = '0;
		end

		res.busy_res = (phase_d != PH_IDLE) && !res.done_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tmr_q   <= '0;
			bit_q   <= '0;
			bstep_q <= 1'b0;
			sh_q    <= '0;
			acc_q   <= '0;
			err_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			tmr_q   <= tmr_d;
			bit_q   <= bit_d;
			bstep_q <= bstep_d;
			sh_q    <= sh_d;
			acc_q   <= acc_d;
			err_q   <= err_d;
		end
	end

endmodule

### rtl/owtr_outreg.sv
module owtr_outreg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  owtr_pkg::result_t     res,
	output logic                  can_load,
	owtr_result_if.source         result
);

	logic              valid_q;
	owtr_pkg::result_t res_q;

	// take a new result when empty or when the held one leaves this cycle
	assign can_load = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load)
			res_q <= res;
	end

	assign result.valid           = valid_q;
	assign result.pull_low        = res_q.pull_low;
	assign result.busy_res        = res_q.busy_res;
	assign result.done_res        = res_q.done_res;
	assign result.no_device       = res_q.no_device;
	assign result.raw_temperature = res_q.raw_temperature;

endmodule

### rtl/onewire_temperature_reader.sv
// Result: registered, presented in the cycle after its tick request is accepted.
// Throughput: one tick request per cycle while the output register can take a result;
// the bus sequencer updates its state in a single pass per tick and the output register
// takes a new result while the held one is being taken.
// Reset: arst_n clears the sequencer to idle, empties the output register and sets
// the conversion wait to 750000 us.
module onewire_temperature_reader (
	input  logic               clk,
	input  logic               arst_n,
	owtr_tick_if.sink          tick,
	owtr_cfg_if.sink           cfg,
	owtr_result_if.source      result
);

	logic [owtr_pkg::CFG_W-1:0] wait_cfg_q;
	owtr_pkg::result_t          res;
	logic                       can_load;
	logic                       step;

	assign cfg.ready  = 1'b1;
	assign tick.ready = can_load;
	assign step       = tick.valid && can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_cfg_q <= owtr_pkg::CFG_W'(750000);
		end else if (cfg.valid) begin
			wait_cfg_q <= cfg.data;
		end
	end

	owtr_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.start_req  (tick.start_req),
		.line_level (tick.line_level),
		.wait_cfg   (wait_cfg_q),
		.res        (res)
	);

	owtr_outreg u_outreg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (tick.valid),
		.res      (res),
		.can_load (can_load),
		.result   (result)
	);

endmodule

### tb/tb_top.sv
module tb_top;

	localparam int CYCLE_LIMIT    = 6_000_000;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int PRINT_CAP      = 40;
	localparam int READS_PER_MODE = 8;
	localparam int N_MODES        = 4;
	localparam int N_DIRECTED     = 11;

	// Idle modes: none, sender gaps, receiver stalls, both
	localparam int SRC_IDLE_PCT [N_MODES]   = '{0, 74, 0, 17};
	localparam int SINK_STALL_PCT [N_MODES] = '{0, 0, 74, 17};

	// Bus timing, in ticks within a slot
	localparam int RST_LOW_TICKS   = 480;
	localparam int PRESENCE_TICK   = 540;
	localparam int RST_LAST_TICK   = 959;
	localparam int WRITE1_LOW      = 10;
	localparam int WRITE0_LOW      = 60;
	localparam int WRITE_LAST_TICK = 69;
	localparam int READ_SAMPLE     = 15;
	localparam int READ_LAST_TICK  = 59;

	typedef enum logic [4:0] {
		SEQ_IDLE, SEQ_RESET1, SEQ_SKIP1, SEQ_CONVERT, SEQ_WAIT,
		SEQ_RESET2, SEQ_SKIP2, SEQ_READCMD, SEQ_READ
	} seq_phase_e;

	typedef struct packed {
		logic                              cfg_write;
		logic [owtr_pkg::CFG_W-1:0]        wait_us;
		logic                              pres1;
		logic                              pres2;
		logic [owtr_pkg::TEMP_W-1:0]       temp;
		logic [6:0]                        start_pct;
		logic                              typed;
		logic                              nodev_exp;
		logic [owtr_pkg::TEMP_W-1:0]       temp_exp;
	} read_case_t;

	// cfg, wait, presence 1/2, sensor value, start %, typed, no_device, value
	localparam read_case_t DIRECTED_READS [N_DIRECTED] = '{
		'{1'b0, 20'd0,       1'b0, 1'b1, 16'h0000, 7'd0,   1'b1, 1'b1, 16'h0000},
		'{1'b1, 20'd0,       1'b1, 1'b1, 16'h0000, 7'd0,   1'b1, 1'b0, 16'h0000},
		'{1'b0, 20'd0,       1'b1, 1'b1, 16'h7FFF, 7'd0,   1'b1, 1'b0, 16'h7FFF},
		'{1'b0, 20'd0,       1'b1, 1'b1, 16'h8000, 7'd0,   1'b1, 1'b0, 16'h8000},
		'{1'b0, 20'd0,       1'b1, 1'b1, 16'hFFFF, 7'd0,   1'b1, 1'b0, 16'hFFFF},
		'{1'b1, 20'd1,       1'b1, 1'b1, 16'h0550, 7'd10,  1'b1, 1'b0, 16'h0550},
		'{1'b1, 20'hFFFFF,   1'b0, 1'b1, 16'h1234, 7'd0,   1'b1, 1'b1, 16'h0000},
		'{1'b1, 20'd3,       1'b1, 1'b0, 16'h1234, 7'd0,   1'b1, 1'b1, 16'h0000},
		'{1'b1, 20'd2,       1'b1, 1'b1, 16'hFC90, 7'd100, 1'b1, 1'b0, 16'hFC90},
		'{1'b1, 20'd17,      1'b1, 1'b1, 16'h5A5A, 7'd30,  1'b0, 1'b0, 16'h0000},
		'{1'b1, 20'd0,       1'b1, 1'b1, 16'hA5A5, 7'd0,   1'b0, 1'b0, 16'h0000}
	};

	logic clk = 1'b0;
	logic arst_n;

	owtr_tick_if   tick ();
	owtr_cfg_if    cfg ();
	owtr_result_if result ();

	onewire_temperature_reader dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.cfg    (cfg),
		.result (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Sequencer copy
	logic [owtr_pkg::CFG_W-1:0]      wait_cfg;
	seq_phase_e                      sq_phase;
	logic [owtr_pkg::TIMER_BITS-1:0] sq_timer;
	logic [2:0]                      sq_bitpos;
	logic                            sq_second_byte;
	logic [7:0]                      sq_shift;
	logic [owtr_pkg::TEMP_W-1:0]     sq_temp;
	logic                            sq_absent;

	owtr_pkg::result_t tick_outcomes [$];
	owtr_pkg::result_t want;

	int src_idle_pct;
	int sink_stall_pct;
	bit holdoff_pending;
	bit holdoff_done;
	int holdoff_left;
	bit seq_finished;
	bit typed_armed;
	logic typed_nodev;
	logic [owtr_pkg::TEMP_W-1:0] typed_temp;

	int unsigned error_count;
	int unsigned results_checked;
	int unsigned ticks_sent;
	int unsigned reads_done;
	int unsigned absent_reads;
	int unsigned waits_written;

	function automatic int unsigned wait_ticks();
		int unsigned w;
		int unsigned tmax;
		w = 32'(wait_cfg);
		tmax = (1 << owtr_pkg::TIMER_BITS) - 1;
		return (w > tmax) ? tmax : w;
	endfunction

	function automatic void enter_phase(seq_phase_e p);
		if (p == SEQ_WAIT && wait_ticks() == 0)
			p = SEQ_RESET2;
		sq_phase = p;
		sq_timer = '0;
		sq_bitpos = '0;
		case (p)
			SEQ_SKIP1, SEQ_SKIP2: sq_shift = owtr_pkg::CMD_SKIP;
			SEQ_CONVERT: sq_shift = owtr_pkg::CMD_CONVERT;
			SEQ_READCMD: sq_shift = owtr_pkg::CMD_READSP;
			SEQ_READ: sq_shift = '0;
			default: ;
		endcase
	endfunction

	function automatic owtr_pkg::result_t sequence_tick(logic start, logic line);
		owtr_pkg::result_t r;
		int unsigned t;
		logic cmd_bit;
		r = '0;
		if (sq_phase == SEQ_IDLE) begin
			if (!start)
				return r;
			sq_absent = 1'b0;
			sq_second_byte = 1'b0;
			sq_temp = '0;
			enter_phase(SEQ_RESET1);
		end
		t = 32'(sq_timer);
		sq_timer = sq_timer + 1'b1;
		case (sq_phase)
			SEQ_RESET1, SEQ_RESET2: begin
				r.pull_low = (t < RST_LOW_TICKS);
				if (t == PRESENCE_TICK && line)
					sq_absent = 1'b1;
				if (t >= RST_LAST_TICK) begin
					if (sq_absent) begin
						r.done_res = 1'b1;
						r.no_device = 1'b1;
						sq_phase = SEQ_IDLE;
						sq_timer = '0;
					end else begin
						enter_phase(sq_phase == SEQ_RESET1 ? SEQ_SKIP1 : SEQ_SKIP2);
					end
				end
			end
			SEQ_SKIP1, SEQ_CONVERT, SEQ_SKIP2, SEQ_READCMD: begin
				cmd_bit = sq_shift[0];
				r.pull_low = (t < (cmd_bit ? WRITE1_LOW : WRITE0_LOW));
				if (t >= WRITE_LAST_TICK) begin
					sq_shift = sq_shift >> 1;
					sq_bitpos = sq_bitpos + 1'b1;
					sq_timer = '0;
					if (sq_bitpos == 3'd0) begin
						case (sq_phase)
							SEQ_SKIP1: enter_phase(SEQ_CONVERT);
							SEQ_CONVERT: enter_phase(SEQ_WAIT);
							SEQ_SKIP2: enter_phase(SEQ_READCMD);
							default: enter_phase(SEQ_READ);
						endcase
					end
				end
			end
			SEQ_WAIT: begin
				if (t + 1 >= wait_ticks())
					enter_phase(SEQ_RESET2);
			end
			SEQ_READ: begin
				r.pull_low = (t == 0);
				if (t == READ_SAMPLE)
					sq_shift = sq_shift | (8'(line) << sq_bitpos);
				if (t >= READ_LAST_TICK) begin
					sq_bitpos = sq_bitpos + 1'b1;
					sq_timer = '0;
					if (sq_bitpos == 3'd0) begin
						if (!sq_second_byte) begin
							sq_temp = {8'h00, sq_shift};
							sq_second_byte = 1'b1;
							sq_shift = '0;
						end else begin
							sq_temp[15:8] = sq_shift;
							r.done_res = 1'b1;
							r.raw_temperature = sq_temp;
							sq_phase = SEQ_IDLE;
							sq_second_byte = 1'b0;
						end
					end
				end
			end
			default: begin
				sq_phase = SEQ_IDLE;
				sq_timer = '0;
			end
		endcase
		r.busy_res = (sq_phase != SEQ_IDLE) && !r.done_res;
		return r;
	endfunction

	// Play the sensor: answer presence and read slots, noise everywhere else
	function automatic logic sensor_level(logic pres1, logic pres2,
			logic [owtr_pkg::TEMP_W-1:0] value);
		if (sq_phase == SEQ_RESET1 && int'(sq_timer) == PRESENCE_TICK)
			return !pres1;
		if (sq_phase == SEQ_RESET2 && int'(sq_timer) == PRESENCE_TICK)
			return !pres2;
		if (sq_phase == SEQ_READ && int'(sq_timer) == READ_SAMPLE)
			return value[{sq_second_byte, sq_bitpos}];
		return logic'($urandom_range(0, 1));
	endfunction

	task automatic report_mismatch(input string what);
		if (error_count < PRINT_CAP)
			$display("MISMATCH at result %0d: %s", results_checked, what);
		error_count++;
	endtask

	task automatic send_tick(input logic start, input logic line);
		owtr_pkg::result_t r;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			tick.valid <= 1'b0;
			@(negedge clk);
		end
		tick.valid <= 1'b1;
		tick.start_req <= start;
		tick.line_level <= line;
		@(posedge clk);
		while (!tick.ready)
			@(posedge clk);
		r = sequence_tick(start, line);
		if (r.done_res) begin
			reads_done++;
			if (r.no_device)
				absent_reads++;
			if (typed_armed) begin
				r.no_device = typed_nodev;
				r.raw_temperature = typed_temp;
				typed_armed = 1'b0;
			end
		end
		seq_finished = r.done_res;
		tick_outcomes.push_back(r);
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		tick.valid <= 1'b0;
		while (tick_outcomes.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_wait(input logic [owtr_pkg::CFG_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		wait_cfg = value;
		waits_written++;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic run_read(input logic pres1, input logic pres2,
			input logic [owtr_pkg::TEMP_W-1:0] value, input int start_pct);
		int unsigned noise;
		noise = $urandom_range(0, 6);
		repeat (noise) send_tick(1'b0, logic'($urandom_range(0, 1)));
		send_tick(1'b1, sensor_level(pres1, pres2, value));
		do
			send_tick(logic'($urandom_range(0, 99) < start_pct), sensor_level(pres1, pres2, value));
		while (!seq_finished);
	endtask

	initial begin
		arst_n = 1'b0;
		tick.valid = 1'b0;
		tick.start_req = 1'b0;
		tick.line_level = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		wait_cfg = 20'd750000;
		sq_phase = SEQ_IDLE;
		sq_timer = '0;
		sq_bitpos = '0;
		sq_second_byte = 1'b0;
		sq_shift = '0;
		sq_temp = '0;
		sq_absent = 1'b0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		holdoff_pending = 1'b0;
		typed_armed = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Quiet bus right after reset
		repeat (8) send_tick(1'b0, logic'($urandom_range(0, 1)));

		foreach (DIRECTED_READS[i]) begin
			settle();
			if (DIRECTED_READS[i].cfg_write)
				write_wait(DIRECTED_READS[i].wait_us);
			typed_armed = DIRECTED_READS[i].typed;
			typed_nodev = DIRECTED_READS[i].nodev_exp;
			typed_temp = DIRECTED_READS[i].temp_exp;
			run_read(DIRECTED_READS[i].pres1, DIRECTED_READS[i].pres2,
				DIRECTED_READS[i].temp, int'(DIRECTED_READS[i].start_pct));
		end

		for (int m = 0; m < N_MODES; m++) begin
			src_idle_pct = SRC_IDLE_PCT[m];
			sink_stall_pct = SINK_STALL_PCT[m];
			for (int k = 0; k < READS_PER_MODE; k++) begin
				int unsigned kind;
				logic [owtr_pkg::CFG_W-1:0] w;
				settle();
				w = ($urandom_range(0, 7) == 0) ? owtr_pkg::CFG_W'($urandom_range(300, 3000))
					: owtr_pkg::CFG_W'($urandom_range(0, 300));
				write_wait(w);
				if (m == 0 && k == 0)
					holdoff_pending = 1'b1;
				// Mostly well-formed reads; drop presence on either reset now and then
				kind = $urandom_range(0, 9);
				run_read(kind != 8, kind != 9, 16'($urandom_range(0, 16'hFFFF)),
					($urandom_range(0, 2) == 0) ? 50 : int'($urandom_range(0, 5)));
			end
		end

		settle();
		repeat (10) @(negedge clk);
		$display("Ran %0d bus ticks, %0d results checked, %0d conversion waits written",
			ticks_sent, results_checked, waits_written);
		$display("Completed %0d reads, %0d of them without presence, over four idle modes",
			reads_done, absent_reads);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off to back up the block
	initial begin
		holdoff_done = 1'b0;
		holdoff_left = 0;
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_pending && !holdoff_done) begin
				holdoff_left = HOLDOFF_CYCLES;
				holdoff_done = 1'b1;
			end
			if (holdoff_left != 0) begin
				result.ready <= 1'b0;
				holdoff_left--;
			end else begin
				result.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready) begin
			results_checked++;
			if (tick_outcomes.size() == 0) begin
				report_mismatch("result with nothing outstanding");
			end else begin
				want = tick_outcomes.pop_front();
				if (result.pull_low !== want.pull_low)
					report_mismatch($sformatf("pull_low %b, want %b", result.pull_low,
						want.pull_low));
				if (result.busy_res !== want.busy_res)
					report_mismatch($sformatf("busy_res %b, want %b", result.busy_res,
						want.busy_res));
				if (result.done_res !== want.done_res)
					report_mismatch($sformatf("done_res %b, want %b", result.done_res,
						want.done_res));
				if (result.no_device !== want.no_device)
					report_mismatch($sformatf("no_device %b, want %b", result.no_device,
						want.no_device));
				if (result.raw_temperature !== want.raw_temperature)
					report_mismatch($sformatf("raw_temperature %0d, want %0d",
						result.raw_temperature, want.raw_temperature));
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timed out after %0d cycles", cycles);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
